// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication check
`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== hdl/tswf_pkg.sv =====
// Package for the three-step weight fit: shared types and constants.
// Depends on nothing.
`default_nettype none
package tswf_pkg;
  localparam int unsigned STEP_W = 24;
  localparam int unsigned MAXC_W = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COARSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MID    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_FINE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT   = 2'd3;

  // loop level selector
  typedef enum logic [1:0] {
    LVL_COARSE = 2'd0,
    LVL_MID    = 2'd1,
    LVL_FINE   = 2'd2
  } lvl_t;

  typedef struct packed {
    logic load;      // take target, reset best
    logic div_start; // start division for level
    lvl_t lvl;
    logic set_start; // load loop counter of lvl from quotient
    logic fine_eval; // evaluate one fine point
    logic dec;       // decrement counter of lvl
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic empty;     // loop start negative
    logic at_zero;   // counter of lvl is zero
    logic fine_stop; // fine loop break or done
  } stat_t;
endpackage
`default_nettype wire

// ===== hdl/tswf_if.sv =====
// Valid/ready channel interface carrying one word of payload.
// Depends on nothing.
`default_nettype none
interface tswf_if #(parameter int unsigned W = 24) (input wire logic clk);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/tswf_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
`default_nettype none
module tswf_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 24
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] q;
  logic [DW:0]   rem;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;

  assign trial = {rem[DW-1:0], q[NW-1]};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q <= num;
        rem <= '0;
        cnt <= CW'(NW);
      end else if (busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          q <= {q[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          q <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/tswf_dp.sv =====
// Datapath: residuals, loop counters, division, error tracking.
// Depends on tswf_pkg and tswf_div.
`default_nettype none
module tswf_dp import tswf_pkg::*; #(
  parameter int unsigned COUNT_BITS = 8,
  parameter int unsigned FRAC_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cmd_t                  cmd,
  output stat_t                      stat,
  input  wire logic [STEP_W-1:0]     target_value,
  input  wire logic [STEP_W-1:0]     k1,
  input  wire logic [STEP_W-1:0]     k2,
  input  wire logic [STEP_W-1:0]     k3,
  input  wire logic [COUNT_BITS-1:0] mx,
  output logic [3*COUNT_BITS-1:0]    best_counts
);
  // residuals stay within [-2^(24+CB+2), 2^24]
  localparam int unsigned RW = STEP_W + COUNT_BITS + 3;
  localparam int unsigned EW = (RW + 1 > FRAC_BITS + 25) ? RW + 1 : FRAC_BITS + 25;
  localparam logic [EW-1:0] BEST_INIT = EW'(64'd10000000 << FRAC_BITS);
  localparam logic [EW-1:0] PREV_INIT = EW'(64'd1000 << FRAC_BITS);

  logic signed [RW-1:0] v, r1, r2, dlt;
  logic [COUNT_BITS:0]  c1, c2, c3;
  logic [EW-1:0]        best_err, prev_err, err;
  logic signed [RW-1:0] res_sel;
  logic [RW-1:0]        mag;
  logic [STEP_W-1:0]    k_sel;
  logic [RW-1:0]        quo;
  logic                 ddone;
  logic [COUNT_BITS:0]  start_cnt;
  logic                 neg;
  logic [COUNT_BITS:0]  cnt_sel;

  always_comb begin
    case (cmd.lvl)
      LVL_COARSE: begin res_sel = v; k_sel = k1; cnt_sel = c1; end
      LVL_MID:    begin res_sel = r1; k_sel = k2; cnt_sel = c2; end
      default:    begin res_sel = r2; k_sel = k3; cnt_sel = c3; end
    endcase
  end

  // divide the magnitude; sign handled below so the quotient truncates toward zero
  assign neg = res_sel[RW-1];
  assign mag = neg ? $unsigned(-res_sel) : $unsigned(res_sel);

  tswf_div #(.NW(RW), .DW(STEP_W)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .num(mag), .den(k_sel), .done(ddone), .quo(quo)
  );

  // negative residual: start is 1 - |q|, empty once |q| reaches 2
  always_comb begin
    if (k_sel == '0) start_cnt = {1'b0, mx};
    else if (neg) start_cnt = (quo == '0 && mx != '0) ? (COUNT_BITS+1)'(1) : '0;
    else if (quo >= RW'(mx)) start_cnt = {1'b0, mx};
    else start_cnt = (COUNT_BITS+1)'(quo) + 1'b1;
  end

  assign dlt = r2 - $signed(RW'(c3) * RW'(k3));
  assign err = dlt[RW-1] ? EW'(-dlt) : EW'(dlt);

  assign stat.div_done = ddone;
  assign stat.empty = neg && ((k_sel == '0) || (quo > RW'(1)));
  assign stat.at_zero = (cnt_sel == '0);
  assign stat.fine_stop = (err > prev_err) || (c3 == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v <= RW'(target_value);
      best_err <= BEST_INIT;
      best_counts <= '0;
    end
    if (cmd.set_start) begin
      case (cmd.lvl)
        LVL_COARSE: c1 <= start_cnt;
        LVL_MID:    c2 <= start_cnt;
        default: begin
          c3 <= start_cnt;
          prev_err <= PREV_INIT;
        end
      endcase
    end
    if (cmd.dec) begin
      case (cmd.lvl)
        LVL_COARSE: c1 <= c1 - 1'b1;
        LVL_MID:    c2 <= c2 - 1'b1;
        default:    c3 <= c3 - 1'b1;
      endcase
    end
    r1 <= v - $signed(RW'(c1) * RW'(k1));
    r2 <= r1 - $signed(RW'(c2) * RW'(k2));
    if (cmd.fine_eval) begin
      prev_err <= err;
      if (err < best_err) begin
        best_err <= err;
        best_counts <= {c1[COUNT_BITS-1:0], c2[COUNT_BITS-1:0], c3[COUNT_BITS-1:0]};
      end
    end
  end
endmodule
`default_nettype wire

// ===== hdl/tswf_ctrl.sv =====
// Controller: sequences the three nested count loops.
// Depends on tswf_pkg.
`default_nettype none
module tswf_ctrl import tswf_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_fire,
  input  wire logic  out_free,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       busy,
  output logic       res_load
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_WAIT = 8'b00000010, // let residuals settle
    S_DIV  = 8'b00000100,
    S_DWT  = 8'b00001000,
    S_SET  = 8'b00010000,
    S_FINE = 8'b00100000,
    S_NEXT = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;
  state_t state, state_next;
  lvl_t lvl, lvl_next;
  logic [1:0] wcnt, wcnt_next;

  always_comb begin
    state_next = state;
    lvl_next = lvl;
    wcnt_next = wcnt;
    cmd = '0;
    cmd.lvl = lvl;
    res_load = 1'b0;
    case (state)
      S_IDLE: if (in_fire) begin
        cmd.load = 1'b1;
        lvl_next = LVL_COARSE;
        wcnt_next = 2'd2;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        wcnt_next = wcnt - 1'b1;
        if (wcnt == 2'd0) state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next = S_DWT;
      end
      S_DWT: if (stat.div_done) begin
        if (stat.empty) begin
          // empty loop: step the enclosing loop
          lvl_next = (lvl == LVL_FINE) ? LVL_MID : LVL_COARSE;
          state_next = S_NEXT;
        end else state_next = S_SET;
      end
      S_SET: begin
        cmd.set_start = 1'b1;
        wcnt_next = 2'd2;
        state_next = S_WAIT;
        case (lvl)
          LVL_COARSE: lvl_next = LVL_MID;
          LVL_MID:    lvl_next = LVL_FINE;
          default:    state_next = S_FINE;
        endcase
      end
      S_FINE: begin
        cmd.fine_eval = 1'b1;
        if (stat.fine_stop) begin
          lvl_next = LVL_MID;
          state_next = S_NEXT;
        end else cmd.dec = 1'b1;
      end
      S_NEXT: begin
        if (stat.at_zero) begin
          if (lvl == LVL_COARSE) state_next = S_DONE;
          else lvl_next = LVL_COARSE;
        end else begin
          cmd.dec = 1'b1;
          lvl_next = (lvl == LVL_COARSE) ? LVL_MID : LVL_FINE;
          wcnt_next = 2'd2;
          state_next = S_WAIT;
        end
      end
      S_DONE: if (out_free) begin
        res_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lvl <= LVL_COARSE;
      wcnt <= '0;
    end else begin
      state <= state_next;
      lvl <= lvl_next;
      wcnt <= wcnt_next;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/three_step_weight_fit.sv =====
// Three-step weight fit: searches counts c1,c2,c3 minimising |target - sum|.
// Each loop start takes one division on the shared bit-serial divider;
// a full search runs to roughly (max+2)^2 divisions plus one evaluation per fine point.
// Throughput: one word at a time; a new target is taken only once the result is loaded.
// Reset: synchronous, active high; config, control and output-valid registers reset.
`default_nettype none
`include "assert_macros.svh"
module three_step_weight_fit import tswf_pkg::*; #(
  parameter int unsigned COUNT_BITS = 8,
  parameter int unsigned FRAC_BITS = 12
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  tswf_if.sink                      in_ch,
  tswf_if.source                    out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [STEP_W-1:0]    cfg_data
);
  logic [STEP_W-1:0] k1, k2, k3;
  logic [MAXC_W-1:0] mxr;
  logic [STEP_W-1:0] tgt;
  cmd_t cmd;
  stat_t stat;
  logic busy, res_load, in_fire;
  logic [3*COUNT_BITS-1:0] best;
  logic ovalid;
  logic [3*COUNT_BITS-1:0] ores;

  always_ff @(posedge clk) begin
    if (rst) begin
      k1 <= STEP_W'(65536);
      k2 <= STEP_W'(11585);
      k3 <= STEP_W'(2048);
      mxr <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_COARSE: k1 <= cfg_data;
        REG_STEP_MID:    k2 <= cfg_data;
        REG_STEP_FINE:   k3 <= cfg_data;
        REG_MAX_COUNT:   mxr <= cfg_data[MAXC_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !busy;
  assign in_fire = in_ch.valid && in_ch.ready;
  always_ff @(posedge clk) if (in_fire) tgt <= in_ch.data;

  tswf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(!ovalid || out_ch.ready),
    .stat(stat), .cmd(cmd), .busy(busy), .res_load(res_load)
  );

  tswf_dp #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .target_value(in_fire ? in_ch.data : tgt), .k1(k1), .k2(k2), .k3(k3),
    .mx(COUNT_BITS'(mxr)), .best_counts(best)
  );

  always_ff @(posedge clk) begin
    if (rst) ovalid <= 1'b0;
    else if (res_load) ovalid <= 1'b1;
    else if (out_ch.ready) ovalid <= 1'b0;
    if (res_load) ores <= best;
  end

  assign out_ch.valid = ovalid;
  assign out_ch.data = {8'(ores[3*COUNT_BITS-1:2*COUNT_BITS]),
                        8'(ores[2*COUNT_BITS-1:COUNT_BITS]),
                        8'(ores[COUNT_BITS-1:0])};

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_fire, busy)
  `ASSERT_IMPL(a_no_accept_busy, clk, rst, busy, !in_ch.ready)
  `ASSERT_NEXT(a_load_sets_valid, clk, rst, res_load, out_ch.valid)
endmodule
`default_nettype wire

// ===== verif/tb_three_step_weight_fit.sv =====
// Testbench for three_step_weight_fit: random and directed targets, checked against
// a behavioural search model held in a small scoreboard class.
// Depends on hdl/tswf_pkg.sv, hdl/tswf_if.sv and hdl/three_step_weight_fit.sv.
`timescale 1ns / 1ps
module tb_three_step_weight_fit;
  import tswf_pkg::*;

  class fit_scoreboard;
    logic [STEP_W-1:0] step_c, step_m, step_f;
    logic [MAXC_W-1:0] max_c;
    logic [23:0] counts_q[$];
    int mismatches;
    int stray;

    function new();
      step_c = 24'd65536;
      step_m = 24'd11585;
      step_f = 24'd2048;
      max_c = 8'd255;
      mismatches = 0;
      stray = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] val);
      case (idx)
        REG_STEP_COARSE: step_c = val;
        REG_STEP_MID:    step_m = val;
        REG_STEP_FINE:   step_f = val;
        REG_MAX_COUNT:   max_c = val[MAXC_W-1:0];
        default: ;
      endcase
    endfunction

    function longint loop_begin(longint resid, longint stp, longint mx);
      longint n;
      if (stp == 0) return (resid >= 0) ? mx : -1;
      n = resid / stp + 1;
      if (n > mx) n = mx;
      return n;
    endfunction

    // full descending search, ties keep the first hit
    function void note_target(logic [23:0] target);
      longint v, k1, k2, k3, mx, i1, i2, i3, r1, r2, d, err, best, prev;
      logic [23:0] best_cnt;
      v = target; k1 = step_c; k2 = step_m; k3 = step_f; mx = max_c;
      best = longint'(10000000) <<< 12;
      best_cnt = '0;
      for (i1 = loop_begin(v, k1, mx); i1 >= 0; i1--) begin
        r1 = v - i1 * k1;
        for (i2 = loop_begin(r1, k2, mx); i2 >= 0; i2--) begin
          r2 = r1 - i2 * k2;
          prev = longint'(1000) <<< 12;
          for (i3 = loop_begin(r2, k3, mx); i3 >= 0; i3--) begin
            d = r2 - i3 * k3;
            err = (d < 0) ? -d : d;
            if (err < best) begin
              best = err;
              best_cnt = {i1[7:0], i2[7:0], i3[7:0]};
            end
            if (err > prev) break;
            prev = err;
          end
        end
      end
      counts_q.push_back(best_cnt);
    endfunction

    function void check_counts(logic [23:0] got);
      logic [23:0] want;
      if (counts_q.size() == 0) begin
        stray++;
        $display("unexpected result word %h", got);
        return;
      end
      want = counts_q.pop_front();
      if (got[23:16] !== want[23:16] || got[15:8] !== want[15:8] || got[7:0] !== want[7:0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("counts mismatch: want c=%0d m=%0d f=%0d got c=%0d m=%0d f=%0d",
                   want[23:16], want[15:8], want[7:0], got[23:16], got[15:8], got[7:0]);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [STEP_W-1:0] cfg_data = '0;
  int in_gap_max = 12;
  int out_gap_max = 12;
  int stall_left = 0;

  always #4 clk = ~clk;

  tswf_if #(.W(24)) in_ch (clk);
  tswf_if #(.W(24)) out_ch (clk);

  three_step_weight_fit dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fit_scoreboard sb = new();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_counts(out_ch.data);
        stall_left = $urandom_range(0, out_gap_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ch.ready <= (stall_left == 0);
    end
  end

  task automatic send_target(logic [23:0] t);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_target(t);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.counts_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_config(logic [23:0] c, logic [23:0] m, logic [23:0] f,
                             logic [7:0] mx);
    write_reg(REG_STEP_COARSE, c);
    write_reg(REG_STEP_MID, m);
    write_reg(REG_STEP_FINE, f);
    write_reg(REG_MAX_COUNT, {16'd0, mx});
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [23:0] c, m, f;
    logic [7:0] mx;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset steps, small targets keep the coarse loop short
    send_target(24'h000000);
    send_target(24'h000001);
    send_target(24'h000800);
    send_target(24'h001000);
    send_target(24'h010000);
    send_target(24'h01FFFF);
    drain();

    load_config(24'hFFFFFF, 24'h800000, 24'h100000, 8'd255);
    send_target(24'hFFFFFF);
    send_target(24'h000000);
    send_target(24'h7FFFFF);
    send_target(24'hABCDEF);
    drain();

    // max count zero: only 0,0,0
    load_config(24'h000100, 24'h000010, 24'h000001, 8'd0);
    send_target(24'hFFFFFF);
    send_target(24'h000005);
    drain();

    // zero step gives a loop start of max count
    load_config(24'h000000, 24'h000003, 24'h000001, 8'd3);
    send_target(24'h000000);
    send_target(24'h000064);
    drain();

    load_config(24'h000001, 24'h000001, 24'h000001, 8'd2);
    send_target(24'hFFFFFF);
    send_target(24'h000004);
    drain();

    for (int p = 0; p < 10; p++) begin
      if ($urandom_range(0, 3) == 0) begin
        c = 24'($urandom_range(24'h100000, 24'hFFFFFF));
        m = 24'($urandom_range(24'h100000, 24'hFFFFFF));
        f = 24'($urandom_range(24'h100000, 24'hFFFFFF));
        mx = 8'd255;
      end else begin
        c = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(0, 255))
                                        : 24'($urandom_range(1, 24'hFFFFFF));
        m = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(0, 255))
                                        : 24'($urandom_range(1, 24'hFFFFFF));
        f = ($urandom_range(0, 7) == 0) ? 24'($urandom_range(1, 255))
                                        : 24'($urandom_range(1, 24'hFFFFFF));
        mx = 8'($urandom_range(0, 7));
      end
      load_config(c, m, f, mx);
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      for (int i = 0; i < 10; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_target(24'($urandom_range(0, 24'h0000FF)));
        else
          send_target(24'($urandom_range(0, 24'hFFFFFF)));
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.stray == 0 && sb.counts_q.size() == 0) begin
      $display("three_step_weight_fit test passed");
    end else begin
      $display("three_step_weight_fit test failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("three_step_weight_fit test failed");
    $finish;
  end
endmodule

// ===== three_step_weight_fit.f =====
+incdir+hdl
hdl/tswf_pkg.sv
hdl/tswf_if.sv
hdl/tswf_div.sv
hdl/tswf_dp.sv
hdl/tswf_ctrl.sv
hdl/three_step_weight_fit.sv
verif/tb_three_step_weight_fit.sv
